/* rtl/vector_normalize_2d_assert.svh */
// ---------------------------------------------------------------------------
// vector_normalize_2d_assert.svh: assertion macros for the normalizer checker
// Expect clk_i and rst_ni in the scope of every use.
// ---------------------------------------------------------------------------
`ifndef VECTOR_NORMALIZE_2D_ASSERT_SVH
`define VECTOR_NORMALIZE_2D_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VN2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VN2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/vn2d_pkg.sv */
// ---------------------------------------------------------------------------
// vn2d_pkg: shared types and constants of the 2D vector normalizer
// Controller states, command and status bundles, configuration defaults.
// ---------------------------------------------------------------------------
package vn2d_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int RATIO_FRAC_BITS_DEF = 14;

  localparam int               SCALE_W     = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_SCALE,
    ST_DIVIDE,
    ST_DONE
  } vn2d_state_e;

  typedef struct packed {
    logic load_in;
    logic square;
    logic sum;
    logic sqrt_step;
    logic scale;
    logic div_step;
    logic div_first;
    logic load_out;
  } vn2d_cmd_t;

  typedef struct packed {
    logic mag_zero;
  } vn2d_status_t;

endpackage

/* rtl/vn2d_ctrl.sv */
// ---------------------------------------------------------------------------
// vn2d_ctrl: sequencer of the 2D vector normalizer
// Walks one transaction through square, sum, root, scale and, unless the magnitude is zero, divide steps.
// ---------------------------------------------------------------------------
module vn2d_ctrl #(
  parameter int COORD_BITS      = vn2d_pkg::COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = vn2d_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  vn2d_pkg::vn2d_status_t status_i,
  output vn2d_pkg::vn2d_cmd_t    cmd_o
);

  localparam int SqrtIters = COORD_BITS + 1;
  localparam int DivIters  = RATIO_FRAC_BITS + 1;
  localparam int IterMax   = (SqrtIters > DivIters) ? SqrtIters : DivIters;
  localparam int CntW      = $clog2(IterMax);

  localparam logic [CntW-1:0] SqrtLast = CntW'(SqrtIters - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(DivIters - 1);

  vn2d_pkg::vn2d_state_e state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      vn2d_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = vn2d_pkg::ST_SQUARE;
      end
      vn2d_pkg::ST_SQUARE: state_d = vn2d_pkg::ST_SUM;
      vn2d_pkg::ST_SUM: begin
        state_d = vn2d_pkg::ST_SQRT;
        cnt_d   = SqrtLast;
      end
      vn2d_pkg::ST_SQRT: begin
        if (cnt_q == '0) state_d = vn2d_pkg::ST_SCALE;
        else cnt_d = cnt_q - 1'b1;
      end
      vn2d_pkg::ST_SCALE: begin
        if (status_i.mag_zero) begin
          state_d = vn2d_pkg::ST_DONE;
        end else begin
          state_d = vn2d_pkg::ST_DIVIDE;
          cnt_d   = DivLast;
        end
      end
      vn2d_pkg::ST_DIVIDE: begin
        if (cnt_q == '0) state_d = vn2d_pkg::ST_DONE;
        else cnt_d = cnt_q - 1'b1;
      end
      vn2d_pkg::ST_DONE: begin
        if (out_free) state_d = vn2d_pkg::ST_IDLE;
      end
      default: state_d = vn2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      vn2d_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      vn2d_pkg::ST_SQUARE: cmd_o.square    = 1'b1;
      vn2d_pkg::ST_SUM:    cmd_o.sum       = 1'b1;
      vn2d_pkg::ST_SQRT:   cmd_o.sqrt_step = 1'b1;
      vn2d_pkg::ST_SCALE:  cmd_o.scale     = 1'b1;
      vn2d_pkg::ST_DIVIDE: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == DivLast);
      end
      vn2d_pkg::ST_DONE:   cmd_o.load_out  = out_free;
      default: cmd_o = '0;
    endcase
  end

  // Set on a new result, drop once the sink takes it.
  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vn2d_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/vn2d_datapath.sv */
// ---------------------------------------------------------------------------
// vn2d_datapath: arithmetic of the 2D vector normalizer
// Differences, squares, bit-serial root, scale product, two serial dividers.
// ---------------------------------------------------------------------------
module vn2d_datapath #(
  parameter int COORD_BITS      = vn2d_pkg::COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = vn2d_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vn2d_pkg::SCALE_W-1:0]        cfg_wdata_i,
  input  logic signed [COORD_BITS-1:0]        dest_x_i,
  input  logic signed [COORD_BITS-1:0]        dest_y_i,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  input  vn2d_pkg::vn2d_cmd_t                 cmd_i,
  output vn2d_pkg::vn2d_status_t              status_o,
  output logic signed [COORD_BITS:0]          delta_x_o,
  output logic signed [COORD_BITS:0]          delta_y_o,
  output logic [COORD_BITS:0]                 magnitude_o,
  output logic [COORD_BITS+8:0]               scaled_magnitude_o,
  output logic signed [RATIO_FRAC_BITS+1:0]   ratio_x_o,
  output logic signed [RATIO_FRAC_BITS+1:0]   ratio_y_o,
  output logic                                zero_length_o
);

  localparam int C      = COORD_BITS;
  localparam int DW     = C + 1;
  localparam int MW     = C + 1;
  localparam int SW     = C + 9;
  localparam int RW     = RATIO_FRAC_BITS + 2;
  localparam int QW     = RATIO_FRAC_BITS + 1;
  localparam int SQ_W   = 2 * C;
  localparam int RAD_W  = 2 * C + 2;
  localparam int REM_W  = C + 4;
  localparam int DREM_W = C + 2;
  localparam int PW     = MW + vn2d_pkg::SCALE_W;

  logic [vn2d_pkg::SCALE_W-1:0] scale_q;
  logic [DW-1:0]    dx_q, dy_q;
  logic [C-1:0]     ax_q, ay_q;
  logic [SQ_W-1:0]  sqx_q, sqy_q;
  logic [RAD_W-1:0] rad_q;
  logic [REM_W-1:0] srem_q;
  logic [MW-1:0]    root_q;
  logic [SW-1:0]    scaled_q;
  logic [DREM_W-1:0] xrem_q, yrem_q;
  logic [QW-1:0]    qx_q, qy_q;
  logic [RW-1:0]    held_x_q, held_y_q;

  logic [DW-1:0]    ax_full, ay_full;
  logic [C-1:0]     ax_w, ay_w;
  logic [SQ_W-1:0]  sqx, sqy;
  logic [REM_W-1:0] srem_sh, trial;
  logic             root_ge;
  logic [PW-1:0]    prod;
  logic [DREM_W-1:0] msor, tx, ty;
  logic             gex, gey;
  logic [RW-1:0]    rx, ry, ratio_x_new, ratio_y_new;
  logic             mag_zero;

  assign ax_full = dx_q[DW-1] ? (~dx_q + 1'b1) : dx_q;
  assign ay_full = dy_q[DW-1] ? (~dy_q + 1'b1) : dy_q;
  assign ax_w    = ax_full[C-1:0];
  assign ay_w    = ay_full[C-1:0];
  assign sqx     = ax_w * ax_w;
  assign sqy     = ay_w * ay_w;

  // Restoring root: bring down two radicand bits, try (root << 2) | 1.
  assign srem_sh = {srem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign root_ge = (srem_sh >= trial);

  assign mag_zero          = (root_q == '0);
  assign status_o.mag_zero = mag_zero;

  assign prod = root_q * scale_q;

  // Magnitude bounds each component, so the first step needs no shift.
  assign msor = {1'b0, root_q};
  assign tx   = cmd_i.div_first ? xrem_q : {xrem_q[DREM_W-2:0], 1'b0};
  assign ty   = cmd_i.div_first ? yrem_q : {yrem_q[DREM_W-2:0], 1'b0};
  assign gex  = (tx >= msor);
  assign gey  = (ty >= msor);

  assign rx          = {1'b0, qx_q};
  assign ry          = {1'b0, qy_q};
  assign ratio_x_new = dx_q[DW-1] ? (~rx + 1'b1) : rx;
  assign ratio_y_new = dy_q[DW-1] ? (~ry + 1'b1) : ry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= vn2d_pkg::SCALE_RESET;
      held_x_q <= '0;
      held_y_q <= '0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (cmd_i.load_out && !mag_zero) begin
        held_x_q <= ratio_x_new;
        held_y_q <= ratio_y_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      dx_q <= {dest_x_i[C-1], dest_x_i} - {pos_x_i[C-1], pos_x_i};
      dy_q <= {dest_y_i[C-1], dest_y_i} - {pos_y_i[C-1], pos_y_i};
    end
    if (cmd_i.square) begin
      ax_q  <= ax_w;
      ay_q  <= ay_w;
      sqx_q <= sqx;
      sqy_q <= sqy;
    end
    if (cmd_i.sum) begin
      rad_q  <= {1'b0, ({1'b0, sqx_q} + {1'b0, sqy_q})};
      srem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      srem_q <= root_ge ? (srem_sh - trial) : srem_sh;
      root_q <= {root_q[MW-2:0], root_ge};
    end
    if (cmd_i.scale) begin
      scaled_q <= prod[PW-1:8];
      xrem_q   <= {2'b00, ax_q};
      yrem_q   <= {2'b00, ay_q};
      qx_q     <= '0;
      qy_q     <= '0;
    end
    if (cmd_i.div_step) begin
      xrem_q <= gex ? (tx - msor) : tx;
      yrem_q <= gey ? (ty - msor) : ty;
      qx_q   <= {qx_q[QW-2:0], gex};
      qy_q   <= {qy_q[QW-2:0], gey};
    end
    if (cmd_i.load_out) begin
      delta_x_o          <= dx_q;
      delta_y_o          <= dy_q;
      magnitude_o        <= root_q;
      scaled_magnitude_o <= scaled_q;
      ratio_x_o          <= mag_zero ? held_x_q : ratio_x_new;
      ratio_y_o          <= mag_zero ? held_y_q : ratio_y_new;
      zero_length_o      <= mag_zero;
    end
  end

endmodule

/* rtl/vector_normalize_2d.sv */
// ---------------------------------------------------------------------------
// vector_normalize_2d: 2D difference, length, scaled length and unit direction
// Takes one transaction at a time and stalls the input until back in idle;
// root and dividers iterate, and a zero-length vector skips the divide.
// Reset: rst_ni async low; idle, no result, scale 1.0, held ratios zero.
// ---------------------------------------------------------------------------
module vector_normalize_2d #(
  parameter int COORD_BITS      = vn2d_pkg::COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = vn2d_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: scale_factor, unsigned Q8.8
  input  logic                              cfg_we_i,
  input  logic [vn2d_pkg::SCALE_W-1:0]      cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      dest_x_i,
  input  logic signed [COORD_BITS-1:0]      dest_y_i,
  input  logic signed [COORD_BITS-1:0]      pos_x_i,
  input  logic signed [COORD_BITS-1:0]      pos_y_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS:0]        delta_x_o,
  output logic signed [COORD_BITS:0]        delta_y_o,
  output logic [COORD_BITS:0]               magnitude_o,
  output logic [COORD_BITS+8:0]             scaled_magnitude_o,
  output logic signed [RATIO_FRAC_BITS+1:0] ratio_x_o,
  output logic signed [RATIO_FRAC_BITS+1:0] ratio_y_o,
  output logic                              zero_length_o
);

  // Flow of one transaction:
  //   accept     latch dest - pos for both axes
  //   square     take absolute values and square them (one multiplier each)
  //   sum        load the radicand into the root shift register
  //   root       COORD_BITS+1 restoring steps, two radicand bits per step
  //   scale      form magnitude * scale >> 8, seed both dividers
  //   divide     RATIO_FRAC_BITS+1 restoring steps, x and y side by side
  //   done       move results into the output register once it is free
  // A zero magnitude skips the divide and repeats the held ratios.
  //
  // The output register decouples the sink: the sequencer returns to idle
  // and takes the next transaction while a result still waits there.

  vn2d_pkg::vn2d_cmd_t    cmd;
  vn2d_pkg::vn2d_status_t status;

  vn2d_ctrl #(
    .COORD_BITS      (COORD_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_vn2d_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Scale register lives with the datapath; the user must write it only while idle, the block does not enforce this.
  vn2d_datapath #(
    .COORD_BITS      (COORD_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_vn2d_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .dest_x_i           (dest_x_i),
    .dest_y_i           (dest_y_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .delta_x_o          (delta_x_o),
    .delta_y_o          (delta_y_o),
    .magnitude_o        (magnitude_o),
    .scaled_magnitude_o (scaled_magnitude_o),
    .ratio_x_o          (ratio_x_o),
    .ratio_y_o          (ratio_y_o),
    .zero_length_o      (zero_length_o)
  );

endmodule

/* rtl/vn2d_checker.sv */
// ---------------------------------------------------------------------------
// vn2d_checker: port-level checks of the 2D vector normalizer
// Bound to the top level; watches handshakes and result consistency.
// ---------------------------------------------------------------------------
`include "vector_normalize_2d_assert.svh"

module vn2d_checker #(
  parameter int COORD_BITS      = vn2d_pkg::COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = vn2d_pkg::RATIO_FRAC_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [COORD_BITS:0]        delta_x_o,
  input logic signed [COORD_BITS:0]        delta_y_o,
  input logic [COORD_BITS:0]               magnitude_o,
  input logic [COORD_BITS+8:0]             scaled_magnitude_o,
  input logic signed [RATIO_FRAC_BITS+1:0] ratio_x_o,
  input logic signed [RATIO_FRAC_BITS+1:0] ratio_y_o,
  input logic                              zero_length_o
);

  localparam int RW = RATIO_FRAC_BITS + 2;

  localparam logic signed [RW-1:0] RatioPos = RW'(1 << RATIO_FRAC_BITS);
  localparam logic signed [RW-1:0] RatioNeg = -RatioPos;

  // A waiting result stays offered until taken.
  `VN2D_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // Zero length exactly when both deltas vanish, and then both magnitudes are zero.
  `VN2D_ASSERT_NOW(a_zero_flag, out_valid_o, zero_length_o == ((delta_x_o == 0) && (delta_y_o == 0)), "zero_length disagrees with deltas")
  `VN2D_ASSERT_NOW(a_zero_mag, out_valid_o && zero_length_o, (magnitude_o == 0) && (scaled_magnitude_o == 0), "nonzero magnitude on zero length")

  // Unit direction never leaves plus or minus one.
  `VN2D_ASSERT_NOW(a_ratio_range, out_valid_o, (ratio_x_o <= RatioPos) && (ratio_x_o >= RatioNeg) && (ratio_y_o <= RatioPos) && (ratio_y_o >= RatioNeg), "ratio out of range")

  // One transaction at a time: busy right after an accept.
  `VN2D_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken while busy")

endmodule

bind vector_normalize_2d vn2d_checker #(
  .COORD_BITS      (COORD_BITS),
  .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
) u_vn2d_checker (.*);
